// ===== src/mbe_pkg.sv =====
// Shared widths and constants for the escape-time unit.
// No dependencies.
package mbe_pkg;

   localparam int FRAC_BITS   = 28;
   localparam int COORD_WIDTH = 32;
   localparam int COUNT_W     = 16;
   localparam int LIMIT_W     = 15;

   // multiplier operand magnitude, below 2.0
   localparam int MAG_W  = FRAC_BITS + 1;
   // product after dropping the fraction, below 4.0
   localparam int PROD_W = 2 * MAG_W - FRAC_BITS;
   // square incl. the saturated value 4.0
   localparam int SQ_W   = FRAC_BITS + 3;
   // z components, worst case |2xy + c| with |xy| < 4.0
   localparam int Z_W = ((COORD_WIDTH > FRAC_BITS + 4) ? COORD_WIDTH : FRAC_BITS + 4) + 2;

   localparam logic [SQ_W-1:0] ESC_LIMIT = {1'b1, {(FRAC_BITS + 2){1'b0}}};
   localparam logic [LIMIT_W-1:0] MAX_ITER_RESET = LIMIT_W'(300);

endpackage

// ===== src/mbe_mul.sv =====
// Shared unsigned fixed-point multiplier with registered, fraction-dropped product.
// Depends on mbe_pkg.
module mbe_mul (
   input  logic                         clock,
   input  logic [mbe_pkg::MAG_W-1:0]    op_a,
   input  logic [mbe_pkg::MAG_W-1:0]    op_b,
   output logic [mbe_pkg::PROD_W-1:0]   prod
);

   logic [2*mbe_pkg::MAG_W-1:0] full_in;
   logic [mbe_pkg::PROD_W-1:0]  prod_ff;

   assign full_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= full_in[2*mbe_pkg::MAG_W-1:mbe_pkg::FRAC_BITS];
   end

   assign prod = prod_ff;

endmodule

// ===== src/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time unit: sequencer and datapath around one shared multiplier.
// Runs n iterations (n = 1 to max_iter+1) per request; one request at a time.
// Each iteration steps through four states: x*y, x^2, y^2 on the single multiplier, then the
// escape and limit test. A new request is taken once the result is registered (ST_HOLD waits on rsp_stall).
// Synchronous active-high reset idles the sequencer, empties the result register
// and sets max_iter to 300. Depends on mbe_pkg and mbe_mul.
module mandelbrot_escape_time (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [mbe_pkg::COORD_WIDTH-1:0] req_c_real,
   input  logic signed [mbe_pkg::COORD_WIDTH-1:0] req_c_imag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mbe_pkg::COUNT_W-1:0]          rsp_iter_count,
   input  logic                                 csr_write_en,
   input  logic [mbe_pkg::LIMIT_W-1:0]          csr_write_data
);

   localparam int ZW = mbe_pkg::Z_W;
   localparam int SW = mbe_pkg::SQ_W;
   localparam int CW = mbe_pkg::COORD_WIDTH;
   localparam int FB = mbe_pkg::FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MXY,
      ST_MXX,
      ST_MYY,
      ST_TEST,
      ST_HOLD
   } state_type;

   state_type                     state_ff, state_in;
   logic signed [CW-1:0]          cr_ff, cr_in, ci_ff, ci_in;
   logic signed [ZW-1:0]          x_ff, x_in, y_ff, y_in;
   logic [SW-1:0]                 xx_ff, xx_in, yy_ff, yy_in;
   logic                          sat_ff, sat_in, sign_ff, sign_in;
   logic [mbe_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [mbe_pkg::LIMIT_W-1:0]   max_iter_ff, max_iter_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mbe_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [mbe_pkg::MAG_W-1:0]     op_a, op_b;
   logic [mbe_pkg::PROD_W-1:0]    prod;
   logic [ZW-1:0]                 x_mag, y_mag;
   logic signed [ZW-1:0]          prod_ext, xy_s, nx, ny, cr_ext, ci_ext;
   logic [SW-1:0]                 sq_val;
   logic [SW:0]                   mod_sum;
   logic                          escape, at_limit, out_free;

   mbe_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign x_mag = x_ff[ZW-1] ? ZW'(-x_ff) : ZW'(x_ff);
   assign y_mag = y_ff[ZW-1] ? ZW'(-y_ff) : ZW'(y_ff);

   always_comb begin
      case (state_ff)
         ST_MXY: begin
            op_a = x_mag[mbe_pkg::MAG_W-1:0];
            op_b = y_mag[mbe_pkg::MAG_W-1:0];
         end
         ST_MXX: begin
            op_a = x_mag[mbe_pkg::MAG_W-1:0];
            op_b = x_mag[mbe_pkg::MAG_W-1:0];
         end
         ST_MYY: begin
            op_a = y_mag[mbe_pkg::MAG_W-1:0];
            op_b = y_mag[mbe_pkg::MAG_W-1:0];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign cr_ext   = {{(ZW - CW){cr_ff[CW-1]}}, cr_ff};
   assign ci_ext   = {{(ZW - CW){ci_ff[CW-1]}}, ci_ff};
   assign prod_ext = {{(ZW - mbe_pkg::PROD_W){1'b0}}, prod};
   assign xy_s     = sign_ff ? -prod_ext : prod_ext;
   assign nx       = $signed({{(ZW - SW){1'b0}}, xx_ff}) - $signed({{(ZW - SW){1'b0}}, yy_ff})
                     + cr_ext;
   assign ny       = (xy_s <<< 1) + ci_ext;
   assign sq_val   = sat_ff ? mbe_pkg::ESC_LIMIT : {{(SW - mbe_pkg::PROD_W){1'b0}}, prod};
   assign mod_sum  = {1'b0, xx_ff} + {1'b0, sq_val};
   assign escape   = mod_sum >= {1'b0, mbe_pkg::ESC_LIMIT};
   assign at_limit = count_ff >= {1'b0, max_iter_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      xx_in        = xx_ff;
      yy_in        = yy_ff;
      sat_in       = sat_ff;
      sign_in      = sign_ff;
      count_in     = count_ff;
      max_iter_in  = csr_write_en ? csr_write_data : max_iter_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cr_in    = req_c_real;
               ci_in    = req_c_imag;
               x_in     = '0;
               y_in     = '0;
               xx_in    = '0;
               yy_in    = '0;
               count_in = '0;
               state_in = ST_MXY;
            end
         end
         ST_MXY: begin
            sign_in  = x_ff[ZW-1] ^ y_ff[ZW-1];
            x_in     = nx;
            state_in = ST_MXX;
         end
         ST_MXX: begin
            y_in     = ny;
            sat_in   = |x_mag[ZW-1:FB+1];
            state_in = ST_MYY;
         end
         ST_MYY: begin
            xx_in    = sq_val;
            sat_in   = |y_mag[ZW-1:FB+1];
            state_in = ST_TEST;
         end
         ST_TEST: begin
            yy_in    = sq_val;
            count_in = count_ff + 1'b1;
            if (escape || at_limit) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = count_ff + 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end else begin
               state_in = ST_MXY;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         max_iter_ff  <= mbe_pkg::MAX_ITER_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         max_iter_ff  <= max_iter_in;
      end
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      xx_ff        <= xx_in;
      yy_ff        <= yy_in;
      sat_ff       <= sat_in;
      sign_ff      <= sign_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_stall      = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iter_count = rsp_count_ff;

endmodule
